// ===== rtl/h1p_pkg.sv =====
package h1p_pkg;

  localparam int LENGTH_BITS_DEFAULT = 40;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_HEAD  = 3'd1,
    PH_BODY  = 3'd2,
    PH_CSIZE = 3'd3,
    PH_CDATA = 3'd4,
    PH_CCR   = 3'd5,
    PH_CLF   = 3'd6,
    PH_CEND  = 3'd7
  } phase_t;

  localparam logic [2:0] KIND_FRAME = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_NAME  = 3'd2;
  localparam logic [2:0] KIND_VALUE = 3'd3;
  localparam logic [2:0] KIND_BODY  = 3'd4;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_CHUNK   = 3'd1;
  localparam logic [2:0] ERR_START   = 3'd2;
  localparam logic [2:0] ERR_HEADER  = 3'd3;
  localparam logic [2:0] ERR_TOOLONG = 3'd4;
  localparam logic [2:0] ERR_VERSION = 3'd5;

  localparam logic [1:0] REG_MAX_LINE  = 2'd0;
  localparam logic [1:0] REG_MAX_LINES = 2'd1;
  localparam logic [1:0] REG_STRICT    = 2'd2;

  localparam logic [1:0] SEL_NONE = 2'd0;
  localparam logic [1:0] SEL_TE   = 2'd1;
  localparam logic [1:0] SEL_CL   = 2'd2;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] lower;
    logic       ws;
    logic       dig;
    logic       hex_ok;
    logic [3:0] hexv;
    logic       tok;
  } cls_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  idx;
    logic [7:0]  data;
    logic        fend;
    logic        done;
    logic        rep;
    logic        minor;
    logic [15:0] status;
    logic [2:0]  err;
  } res_t;

  typedef struct packed {
    phase_t      phase;
    logic        prev_cr;
    logic [16:0] line_bytes;
    logic [8:0]  header_lines;
    logic [3:0]  token_position;
    logic [3:0]  version_match;
    logic [4:0]  name_match;
    logic [2:0]  value_match;
    logic        chunked_flag;
    logic        length_known;
    logic        cl_bad;
    logic [15:0] rep_status;
    logic        rep_is;
    logic        rep_minor;
    logic        in_tok;
    logic [1:0]  tok_count;
    logic        ver_fail;
    logic        tok_minor;
    logic        pfx_fail;
    logic [15:0] st_val;
    logic        st_bad;
    logic        st_stop;
    logic        colon_seen;
    logic        first_ok;
    logic [1:0]  name_sel;
    logic        name_fail;
    logic [1:0]  hit_sel;
    logic        te_started;
    logic        te_fail;
    logic        te_trail;
    logic        cl_started;
    logic        cl_stop;
    logic        cl_digits;
    logic        cl_over;
    logic        cs_stop;
    logic        cs_digits;
    logic        cs_over;
  } ctl_t;

  function automatic logic [7:0] to_lower(logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return c + 8'd32;
    return c;
  endfunction

  function automatic cls_t classify(logic [7:0] c);
    cls_t k;
    k.data   = c;
    k.lower  = to_lower(c);
    k.ws     = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    k.dig    = (c >= 8'h30 && c <= 8'h39);
    k.hex_ok = 1'b1;
    k.hexv   = 4'd0;
    if (k.dig) k.hexv = c[3:0];
    else if (k.lower >= 8'h61 && k.lower <= 8'h66) k.hexv = 4'(k.lower - 8'h57);
    else k.hex_ok = 1'b0;
    k.tok = k.dig || (k.lower >= 8'h61 && k.lower <= 8'h7A) ||
            (c inside {8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2D,
                       8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E});
    return k;
  endfunction

  function automatic logic [7:0] ver_char(logic [2:0] i);
    case (i)
      3'd0: return "H";
      3'd1: return "T";
      3'd2: return "T";
      3'd3: return "P";
      3'd4: return "/";
      3'd5: return "1";
      3'd6: return ".";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] te_char(logic [4:0] i);
    case (i)
      5'd0: return "t";   5'd1: return "r";   5'd2: return "a";   5'd3: return "n";
      5'd4: return "s";   5'd5: return "f";   5'd6: return "e";   5'd7: return "r";
      5'd8: return "-";   5'd9: return "e";   5'd10: return "n";  5'd11: return "c";
      5'd12: return "o";  5'd13: return "d";  5'd14: return "i";  5'd15: return "n";
      5'd16: return "g";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] cl_char(logic [4:0] i);
    case (i)
      5'd0: return "c";   5'd1: return "o";   5'd2: return "n";   5'd3: return "t";
      5'd4: return "e";   5'd5: return "n";   5'd6: return "t";   5'd7: return "-";
      5'd8: return "l";   5'd9: return "e";   5'd10: return "n";  5'd11: return "g";
      5'd12: return "t";  5'd13: return "h";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ch_char(logic [2:0] i);
    case (i)
      3'd0: return "c";
      3'd1: return "h";
      3'd2: return "u";
      3'd3: return "n";
      3'd4: return "k";
      3'd5: return "e";
      3'd6: return "d";
      default: return 8'h00;
    endcase
  endfunction

  function automatic ctl_t line_clear(ctl_t x);
    ctl_t y;
    y = x;
    y.line_bytes     = '0;
    y.token_position = '0;
    y.version_match  = '0;
    y.name_match     = '0;
    y.value_match    = '0;
    y.in_tok         = 1'b0;
    y.tok_count      = '0;
    y.ver_fail       = 1'b0;
    y.tok_minor      = 1'b0;
    y.pfx_fail       = 1'b0;
    y.st_val         = '0;
    y.st_bad         = 1'b0;
    y.st_stop        = 1'b0;
    y.colon_seen     = 1'b0;
    y.first_ok       = 1'b0;
    y.name_sel       = SEL_NONE;
    y.name_fail      = 1'b0;
    y.hit_sel        = SEL_NONE;
    y.te_started     = 1'b0;
    y.te_fail        = 1'b0;
    y.te_trail       = 1'b0;
    y.cl_started     = 1'b0;
    y.cl_stop        = 1'b0;
    y.cl_digits      = 1'b0;
    y.cl_over        = 1'b0;
    y.cs_stop        = 1'b0;
    y.cs_digits      = 1'b0;
    y.cs_over        = 1'b0;
    return y;
  endfunction

endpackage

// ===== rtl/h1p_front.sv =====
module h1p_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  output logic          push,
  input  logic          push_ready,
  output h1p_pkg::cls_t push_cls
);

  logic          fv;
  h1p_pkg::cls_t fcls;

  assign in_ready = !fv || push_ready;
  assign push     = fv;
  assign push_cls = fcls;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_valid && in_ready) begin
      fv <= 1'b1;
    end else if (push_ready) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fcls <= h1p_pkg::classify(in_byte);
    end
  end

endmodule

// ===== rtl/h1p_queue.sv =====
module h1p_queue #(
  parameter int DEPTH = h1p_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  h1p_pkg::cls_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output h1p_pkg::cls_t rd_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  h1p_pkg::cls_t mem [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] count;
  logic          wr_en;
  logic          rd_en;

  assign wr_ready = count != CW'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rp];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr_en) wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + PW'(1);
      if (rd_en) rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + PW'(1);
      if (wr_en && !rd_en) count <= count + CW'(1);
      else if (!wr_en && rd_en) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_data;
  end

endmodule

// ===== rtl/h1p_back.sv =====
module h1p_back #(
  parameter int LENGTH_BITS = h1p_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  input  logic          q_valid,
  output logic          q_pop,
  input  h1p_pkg::cls_t q_cls,
  output logic          o_valid,
  input  logic          o_ready,
  output h1p_pkg::res_t o_res
);

  localparam int L = LENGTH_BITS;

  logic [15:0]   max_line_length;
  logic [7:0]    max_header_lines;
  logic          strict_names;

  h1p_pkg::ctl_t s;
  h1p_pkg::ctl_t n;
  logic [L-1:0]  body_rem, body_rem_next;
  logic [L-1:0]  chunk_rem, chunk_rem_next;
  logic [L-1:0]  cl_val, cl_val_next;
  logic [L-1:0]  cs_val, cs_val_next;
  h1p_pkg::res_t r;
  logic          bubble;
  logic          step;

  function automatic h1p_pkg::ctl_t tok_close(h1p_pkg::ctl_t x);
    h1p_pkg::ctl_t y;
    y = x;
    if (x.in_tok) begin
      if (x.token_position == 4'd8 && !x.ver_fail) begin
        if (x.tok_count == 2'd0) y.version_match = y.version_match | {2'b00, x.tok_minor, 1'b1};
        if (x.tok_count == 2'd2) y.version_match = y.version_match | {x.tok_minor, 1'b1, 2'b00};
      end
      if (x.tok_count != 2'd3) y.tok_count = x.tok_count + 2'd1;
      y.in_tok = 1'b0;
    end
    return y;
  endfunction

  // a CR followed by anything but LF is replayed as line content in a step that pops nothing
  assign bubble = s.prev_cr && q_cls.data != h1p_pkg::CH_LF &&
                  (s.phase == h1p_pkg::PH_START || s.phase == h1p_pkg::PH_HEAD ||
                   s.phase == h1p_pkg::PH_CSIZE || s.phase == h1p_pkg::PH_CEND);
  assign step   = q_valid && (bubble || !o_valid || o_ready);
  assign q_pop  = step && !bubble;

  always_comb begin
    h1p_pkg::cls_t k;
    logic [19:0]   st_tmp;
    logic [L+3:0]  cl_tmp;
    logic [2:0]    p;
    logic          do_content;
    logic          rep_line;
    n              = s;
    body_rem_next  = body_rem;
    chunk_rem_next = chunk_rem;
    cl_val_next    = cl_val;
    cs_val_next    = cs_val;
    r              = '0;
    k              = bubble ? h1p_pkg::classify(h1p_pkg::CH_CR) : q_cls;
    st_tmp         = '0;
    cl_tmp         = '0;
    p              = '0;
    do_content     = 1'b0;
    rep_line       = 1'b0;
    r.data         = q_cls.data;

    if (s.phase == h1p_pkg::PH_BODY) begin
      r.kind        = h1p_pkg::KIND_BODY;
      body_rem_next = body_rem - L'(1);
      if (body_rem_next == '0) begin
        r.fend = 1'b1;
        r.done = 1'b1;
      end
    end else if (s.phase == h1p_pkg::PH_CDATA) begin
      r.kind         = h1p_pkg::KIND_BODY;
      chunk_rem_next = chunk_rem - L'(1);
      if (chunk_rem_next == '0) begin
        r.fend  = 1'b1;
        n.phase = h1p_pkg::PH_CCR;
      end
    end else if (s.phase == h1p_pkg::PH_CCR) begin
      if (k.data == h1p_pkg::CH_CR) n.phase = h1p_pkg::PH_CLF;
      else r.err = h1p_pkg::ERR_CHUNK;
    end else if (s.phase == h1p_pkg::PH_CLF) begin
      if (k.data == h1p_pkg::CH_LF) begin
        n.phase = h1p_pkg::PH_CSIZE;
        r.fend  = 1'b1;
      end else begin
        r.err = h1p_pkg::ERR_CHUNK;
      end
    end else if (s.prev_cr && k.data == h1p_pkg::CH_LF) begin
      n.prev_cr = 1'b0;
      r.fend    = 1'b1;
      case (s.phase)
        h1p_pkg::PH_START: begin
          n        = tok_close(n);
          rep_line = n.line_bytes >= 17'd5 && !n.pfx_fail;
          if (rep_line) begin
            if (n.tok_count < 2'd2 || n.st_bad) r.err = h1p_pkg::ERR_START;
            else if (!n.version_match[0]) r.err = h1p_pkg::ERR_VERSION;
            else begin
              n.rep_status = n.st_val;
              n.rep_is     = 1'b1;
              n.rep_minor  = n.version_match[1];
              n.phase      = h1p_pkg::PH_HEAD;
            end
          end else begin
            if (n.tok_count != 2'd3) r.err = h1p_pkg::ERR_START;
            else if (!n.version_match[2]) r.err = h1p_pkg::ERR_VERSION;
            else begin
              n.rep_minor = n.version_match[3];
              n.phase     = h1p_pkg::PH_HEAD;
            end
          end
        end
        h1p_pkg::PH_HEAD: begin
          if (n.line_bytes == '0) begin
            if (n.chunked_flag) n.phase = h1p_pkg::PH_CSIZE;
            else if (n.length_known) begin
              if (n.cl_bad) r.err = h1p_pkg::ERR_HEADER;
              else if (body_rem != '0) n.phase = h1p_pkg::PH_BODY;
              else r.done = 1'b1;
            end else r.done = 1'b1;
          end else if (n.line_bytes > {1'b0, max_line_length}) begin
            r.err = h1p_pkg::ERR_TOOLONG;
          end else begin
            if (!n.header_lines[8]) n.header_lines = n.header_lines + 9'd1;
            if (n.header_lines > {1'b0, max_header_lines}) r.err = h1p_pkg::ERR_TOOLONG;
            else if (!n.colon_seen) r.err = h1p_pkg::ERR_HEADER;
            else if (strict_names && !n.first_ok) r.err = h1p_pkg::ERR_HEADER;
            else if (n.hit_sel == h1p_pkg::SEL_TE) begin
              n.chunked_flag = n.te_started && !n.te_fail && n.value_match == 3'd7;
            end else if (n.hit_sel == h1p_pkg::SEL_CL) begin
              n.length_known = 1'b1;
              body_rem_next  = cl_val;
              n.cl_bad       = !n.cl_digits || n.cl_over;
            end
          end
        end
        h1p_pkg::PH_CSIZE: begin
          if (!n.cs_digits || n.cs_over) r.err = h1p_pkg::ERR_HEADER;
          else begin
            chunk_rem_next = cs_val;
            n.phase = (cs_val != '0) ? h1p_pkg::PH_CDATA : h1p_pkg::PH_CEND;
          end
        end
        default: begin
          if (n.line_bytes != '0) r.err = h1p_pkg::ERR_CHUNK;
          else r.done = 1'b1;
        end
      endcase
      n           = h1p_pkg::line_clear(n);
      cl_val_next = '0;
      cs_val_next = '0;
    end else if (bubble) begin
      n.prev_cr  = 1'b0;
      do_content = 1'b1;
    end else if (k.data == h1p_pkg::CH_CR) begin
      n.prev_cr = 1'b1;
    end else begin
      do_content = 1'b1;
    end

    if (do_content) begin
      if (n.phase == h1p_pkg::PH_START && n.line_bytes < 17'd5 &&
          k.data != h1p_pkg::ver_char(n.line_bytes[2:0])) n.pfx_fail = 1'b1;
      if (!n.line_bytes[16]) n.line_bytes = n.line_bytes + 17'd1;
      case (n.phase)
        h1p_pkg::PH_START: begin
          if (k.ws) begin
            r.fend = n.in_tok;
            n      = tok_close(n);
          end else begin
            if (!n.in_tok) begin
              n.in_tok         = 1'b1;
              n.token_position = '0;
              n.ver_fail       = 1'b0;
              if (n.tok_count == 2'd1) begin
                n.st_val  = '0;
                n.st_bad  = 1'b0;
                n.st_stop = 1'b0;
              end
            end
            p = n.token_position[2:0];
            if (n.token_position < 4'd7) begin
              if (k.data != h1p_pkg::ver_char(p)) n.ver_fail = 1'b1;
            end else if (n.token_position == 4'd7) begin
              if (k.data == "0" || k.data == "1") n.tok_minor = k.data[0];
              else n.ver_fail = 1'b1;
            end else begin
              n.ver_fail = 1'b1;
            end
            if (n.tok_count == 2'd1 && !n.st_stop) begin
              if (k.dig) begin
                st_tmp = ({4'd0, n.st_val} << 3) + ({4'd0, n.st_val} << 1) + {16'd0, k.hexv};
                if (st_tmp > 20'd65535) begin
                  n.st_bad  = 1'b1;
                  n.st_stop = 1'b1;
                  n.st_val  = '0;
                end else begin
                  n.st_val = st_tmp[15:0];
                end
              end else begin
                if (n.token_position == 4'd0) n.st_bad = 1'b1;
                n.st_stop = 1'b1;
              end
            end
            if (n.token_position != 4'd15) n.token_position = n.token_position + 4'd1;
            r.kind = h1p_pkg::KIND_START;
            r.idx  = (n.tok_count < 2'd2) ? n.tok_count : 2'd2;
          end
        end
        h1p_pkg::PH_HEAD: begin
          if (!n.colon_seen) begin
            if (k.data == h1p_pkg::CH_COLON) begin
              n.colon_seen = 1'b1;
              if (!n.name_fail && ((n.name_sel == h1p_pkg::SEL_TE && n.name_match == 5'd17) ||
                                   (n.name_sel == h1p_pkg::SEL_CL && n.name_match == 5'd14)))
                n.hit_sel = n.name_sel;
              r.fend = 1'b1;
            end else begin
              if (n.name_match == '0) begin
                n.first_ok = k.tok;
                n.name_sel = (k.lower == "t") ? h1p_pkg::SEL_TE :
                             (k.lower == "c") ? h1p_pkg::SEL_CL : h1p_pkg::SEL_NONE;
                if (n.name_sel == h1p_pkg::SEL_NONE) n.name_fail = 1'b1;
              end
              if (!n.name_fail) begin
                if (n.name_sel == h1p_pkg::SEL_TE) begin
                  if (n.name_match >= 5'd17 || k.lower != h1p_pkg::te_char(n.name_match))
                    n.name_fail = 1'b1;
                end else begin
                  if (n.name_match >= 5'd14 || k.lower != h1p_pkg::cl_char(n.name_match))
                    n.name_fail = 1'b1;
                end
              end
              if (n.name_match != 5'd31) n.name_match = n.name_match + 5'd1;
              r.kind = h1p_pkg::KIND_NAME;
            end
          end else begin
            r.kind = h1p_pkg::KIND_VALUE;
            if (k.ws) begin
              if (n.te_started) begin
                if (n.value_match != 3'd7) n.te_fail = 1'b1;
                else n.te_trail = 1'b1;
              end
            end else begin
              n.te_started = 1'b1;
              if (n.te_trail || n.value_match == 3'd7 ||
                  k.lower != h1p_pkg::ch_char(n.value_match)) n.te_fail = 1'b1;
              else n.value_match = n.value_match + 3'd1;
            end
            if (n.cl_started || !k.ws) begin
              n.cl_started = 1'b1;
              if (!n.cl_stop) begin
                if (k.dig) begin
                  cl_tmp = ({4'd0, cl_val} << 3) + ({4'd0, cl_val} << 1) +
                           (L+4)'(k.hexv);
                  if (cl_tmp[L+3:L] != 4'd0) begin
                    n.cl_over = 1'b1;
                    n.cl_stop = 1'b1;
                  end else begin
                    cl_val_next = cl_tmp[L-1:0];
                    n.cl_digits = 1'b1;
                  end
                end else begin
                  n.cl_stop = 1'b1;
                end
              end
            end
          end
        end
        h1p_pkg::PH_CSIZE: begin
          if (!n.cs_stop) begin
            if (!k.hex_ok) n.cs_stop = 1'b1;
            else if (cs_val[L-1:L-4] != 4'd0) begin
              n.cs_over = 1'b1;
              n.cs_stop = 1'b1;
            end else begin
              cs_val_next = {cs_val[L-5:0], k.hexv};
              n.cs_digits = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (n.phase == h1p_pkg::PH_START) begin
      r.rep = n.line_bytes >= 17'd5 && !n.pfx_fail;
    end else begin
      r.rep    = n.rep_is;
      r.minor  = n.rep_minor;
      r.status = n.rep_status;
    end

    if (r.done || r.err != h1p_pkg::ERR_NONE) begin
      n              = '0;
      body_rem_next  = '0;
      chunk_rem_next = '0;
      cl_val_next    = '0;
      cs_val_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_length  <= 16'd8192;
      max_header_lines <= 8'd100;
      strict_names     <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        h1p_pkg::REG_MAX_LINE:  max_line_length  <= cfg_data;
        h1p_pkg::REG_MAX_LINES: max_header_lines <= cfg_data[7:0];
        h1p_pkg::REG_STRICT:    strict_names     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s         <= '0;
      body_rem  <= '0;
      chunk_rem <= '0;
      cl_val    <= '0;
      cs_val    <= '0;
      o_valid   <= 1'b0;
    end else begin
      if (step) begin
        s         <= n;
        body_rem  <= body_rem_next;
        chunk_rem <= chunk_rem_next;
        cl_val    <= cl_val_next;
        cs_val    <= cs_val_next;
      end
      if (q_pop) o_valid <= 1'b1;
      else if (o_ready) o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) o_res <= r;
  end

endmodule

// ===== rtl/http1_message_stream_parser_unit.sv =====
// Path from input accept to result valid: classify register, queue, result
// register; a CR that is not followed by LF is replayed in an extra back-end step.
// Throughput: one byte per cycle while m_tready is high; a replayed lone CR pops no byte.
// Reset: rst synchronous, active high; clears message state and queue and
// loads register defaults (8192, 100, strict names on).
module http1_message_stream_parser_unit #(
  parameter int LENGTH_BITS = h1p_pkg::LENGTH_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = h1p_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] data_byte, [8] field_end, [9] is_reply,
                                 // [10] minor_version, [26:11] reply_status,
                                 // [29:27] error_code, [31:30] zero
  output logic [4:0]  m_tuser,   // [2:0] byte_kind, [4:3] field_index
  output logic        m_tlast,   // message_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic          f_push;
  logic          f_ready;
  h1p_pkg::cls_t f_cls;
  logic          q_valid;
  logic          q_pop;
  h1p_pkg::cls_t q_cls;
  h1p_pkg::res_t res;

  assign cfg_ready = 1'b1;

  h1p_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .push       (f_push),
    .push_ready (f_ready),
    .push_cls   (f_cls)
  );

  h1p_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_push),
    .wr_ready (f_ready),
    .wr_data  (f_cls),
    .rd_valid (q_valid),
    .rd_ready (q_pop),
    .rd_data  (q_cls)
  );

  h1p_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cls     (q_cls),
    .o_valid   (m_tvalid),
    .o_ready   (m_tready),
    .o_res     (res)
  );

  assign m_tdata = {2'b00, res.err, res.status, res.minor, res.rep, res.fend, res.data};
  assign m_tuser = {res.idx, res.kind};
  assign m_tlast = res.done;

`ifndef SYNTHESIS
  a_done_no_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[29:27] == h1p_pkg::ERR_NONE)
    else $error("message done together with an error");

  a_idx_start_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2:0] != h1p_pkg::KIND_START |-> m_tuser[4:3] == 2'd0)
    else $error("field index outside start line");

  a_start_unlatched: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2:0] == h1p_pkg::KIND_START |-> m_tdata[26:10] == 17'd0)
    else $error("version or status set during start line");
`endif

endmodule

// ===== dv/http1_message_stream_parser_unit_tb.sv =====
`timescale 1ns / 100ps

module http1_message_stream_parser_unit_tb;

  localparam int LBITS = h1p_pkg::LENGTH_BITS_DEFAULT;
  localparam logic [LBITS-1:0] LEN_TOP = '1;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [4:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  http1_message_stream_parser_unit dut (.*);

  always #4 clk = ~clk;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  idx;
    logic [7:0]  data;
    logic        fend;
    logic        done;
    logic        rep;
    logic        minor;
    logic [15:0] status;
    logic [2:0]  err;
  } tag_t;

  tag_t tag_q[$];
  int   mismatches = 0;
  int   idle_cycles = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   bytes_sent = 0;
  bit   hold_recv = 1'b0;

  // parser model state
  logic [15:0] cfg_max_line = 16'd8192;
  logic [7:0]  cfg_max_lines = 8'd100;
  logic        cfg_strict = 1'b1;

  h1p_pkg::phase_t ph;
  logic        pcr;
  int unsigned lbytes, hlines;
  int unsigned tpos, vmatch, nmatch, vmt;
  logic        chunked, lknown, clbad;
  logic [LBITS-1:0] body_left, chunk_left;
  logic [15:0] r_status;
  logic        r_is, r_minor;
  logic        in_tok, ver_fail, tok_minor, pfx_fail, st_bad, st_stop;
  int unsigned tok_count, st_val;
  logic        colon_seen, first_ok, name_fail, te_started, te_fail, te_trail;
  logic [1:0]  name_sel, hit_sel;
  logic        cl_started, cl_stop, cl_digits, cl_over;
  logic [LBITS-1:0] cl_val, cs_val;
  logic        cs_stop, cs_digits, cs_over;
  tag_t        t;

  function automatic logic isws(logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction
  function automatic logic isdig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic [7:0] lc(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction
  function automatic logic istok(logic [7:0] c);
    string s;
    s = "!#$%&'*+-.^_`|~";
    if (isdig(c) || (lc(c) >= "a" && lc(c) <= "z")) return 1'b1;
    for (int i = 0; i < s.len(); i++) if (s[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  task automatic clear_line();
    lbytes = 0; tpos = 0; vmatch = 0; nmatch = 0; vmt = 0;
    in_tok = 0; tok_count = 0; ver_fail = 0; tok_minor = 0; pfx_fail = 0;
    st_val = 0; st_bad = 0; st_stop = 0;
    colon_seen = 0; first_ok = 0; name_sel = h1p_pkg::SEL_NONE; name_fail = 0;
    hit_sel = h1p_pkg::SEL_NONE;
    te_started = 0; te_fail = 0; te_trail = 0;
    cl_started = 0; cl_stop = 0; cl_digits = 0; cl_over = 0; cl_val = 0;
    cs_stop = 0; cs_digits = 0; cs_over = 0; cs_val = 0;
  endtask

  task automatic clear_message();
    ph = h1p_pkg::PH_START; pcr = 0; hlines = 0; chunked = 0; lknown = 0; clbad = 0;
    body_left = 0; chunk_left = 0; r_status = 0; r_is = 0; r_minor = 0;
    clear_line();
  endtask

  task automatic bump_line();
    if (lbytes < 65536) lbytes++;
  endtask

  task automatic close_token();
    if (!in_tok) return;
    if (tpos == 8 && !ver_fail) begin
      if (tok_count == 0) vmatch |= 1 | (tok_minor << 1);
      if (tok_count == 2) vmatch |= 4 | (tok_minor << 3);
    end
    if (tok_count < 3) tok_count++;
    in_tok = 0;
  endtask

  task automatic start_line_byte(logic [7:0] c);
    string pfx;
    int unsigned p;
    pfx = "HTTP/1.";
    if (lbytes < 5 && c != pfx[lbytes]) pfx_fail = 1;
    bump_line();
    if (isws(c)) begin
      t.kind = h1p_pkg::KIND_FRAME; t.fend = in_tok;
      close_token();
      return;
    end
    if (!in_tok) begin
      in_tok = 1; tpos = 0; ver_fail = 0;
      if (tok_count == 1) begin
        st_val = 0; st_bad = 0; st_stop = 0;
      end
    end
    p = tpos;
    if (p < 7) begin
      if (c != pfx[p]) ver_fail = 1;
    end else if (p == 7) begin
      if (c == "0" || c == "1") tok_minor = c[0];
      else ver_fail = 1;
    end else ver_fail = 1;
    if (tpos < 15) tpos++;
    if (tok_count == 1 && !st_stop) begin
      if (isdig(c)) begin
        st_val = st_val * 10 + (c - "0");
        if (st_val > 65535) begin
          st_bad = 1; st_stop = 1; st_val = 0;
        end
      end else begin
        if (p == 0) st_bad = 1;
        st_stop = 1;
      end
    end
    t.kind = h1p_pkg::KIND_START;
    t.idx = 2'(tok_count < 2 ? tok_count : 2);
    t.fend = 0;
  endtask

  task automatic header_byte(logic [7:0] c);
    string te, cl, ch;
    logic [LBITS-1:0] d;
    te = "transfer-encoding"; cl = "content-length"; ch = "chunked";
    bump_line();
    if (!colon_seen) begin
      if (c == h1p_pkg::CH_COLON) begin
        colon_seen = 1;
        if (!name_fail && ((name_sel == h1p_pkg::SEL_TE && nmatch == 17) ||
                           (name_sel == h1p_pkg::SEL_CL && nmatch == 14))) hit_sel = name_sel;
        t.kind = h1p_pkg::KIND_FRAME; t.fend = 1;
        return;
      end
      if (nmatch == 0) begin
        first_ok = istok(c);
        name_sel = lc(c) == "t" ? h1p_pkg::SEL_TE :
                   (lc(c) == "c" ? h1p_pkg::SEL_CL : h1p_pkg::SEL_NONE);
        if (name_sel == h1p_pkg::SEL_NONE) name_fail = 1;
      end
      if (!name_fail) begin
        if (name_sel == h1p_pkg::SEL_TE) begin
          if (nmatch >= 17 || lc(c) != te[nmatch]) name_fail = 1;
        end else if (nmatch >= 14 || lc(c) != cl[nmatch]) name_fail = 1;
      end
      if (nmatch < 31) nmatch++;
      t.kind = h1p_pkg::KIND_NAME;
      return;
    end
    t.kind = h1p_pkg::KIND_VALUE;
    if (isws(c)) begin
      if (te_started) begin
        if (vmt < 7) te_fail = 1; else te_trail = 1;
      end
    end else begin
      te_started = 1;
      if (te_trail || vmt >= 7 || lc(c) != ch[vmt]) te_fail = 1;
      else vmt++;
    end
    if (!cl_started && isws(c)) return;
    cl_started = 1;
    if (cl_stop) return;
    if (isdig(c)) begin
      d = c - "0";
      if (cl_val > (LEN_TOP - d) / 10) begin
        cl_over = 1; cl_stop = 1;
      end else begin
        cl_val = cl_val * 10 + d; cl_digits = 1;
      end
    end else cl_stop = 1;
  endtask

  task automatic size_byte(logic [7:0] c);
    int h;
    bump_line();
    if (cs_stop) return;
    if (isdig(c)) h = c - "0";
    else if (lc(c) >= "a" && lc(c) <= "f") h = lc(c) - "a" + 10;
    else h = -1;
    if (h < 0) begin
      cs_stop = 1; return;
    end
    if (cs_val > (LEN_TOP >> 4)) begin
      cs_over = 1; cs_stop = 1; return;
    end
    cs_val = (cs_val << 4) | LBITS'(h);
    cs_digits = 1;
  endtask

  task automatic line_byte(logic [7:0] c);
    t.kind = h1p_pkg::KIND_FRAME; t.idx = 0; t.fend = 0;
    case (ph)
      h1p_pkg::PH_START: start_line_byte(c);
      h1p_pkg::PH_HEAD: header_byte(c);
      h1p_pkg::PH_CSIZE: size_byte(c);
      default: bump_line();
    endcase
  endtask

  task automatic finish_line();
    logic rp;
    case (ph)
      h1p_pkg::PH_START: begin
        close_token();
        rp = lbytes >= 5 && !pfx_fail;
        if (rp) begin
          if (tok_count < 2 || st_bad) t.err = h1p_pkg::ERR_START;
          else if (!vmatch[0]) t.err = h1p_pkg::ERR_VERSION;
          else begin
            r_status = 16'(st_val); r_is = 1; r_minor = vmatch[1]; ph = h1p_pkg::PH_HEAD;
          end
        end else begin
          if (tok_count < 3) t.err = h1p_pkg::ERR_START;
          else if (!vmatch[2]) t.err = h1p_pkg::ERR_VERSION;
          else begin
            r_status = 0; r_is = 0; r_minor = vmatch[3]; ph = h1p_pkg::PH_HEAD;
          end
        end
      end
      h1p_pkg::PH_HEAD: begin
        if (lbytes == 0) begin
          if (chunked) ph = h1p_pkg::PH_CSIZE;
          else if (lknown) begin
            if (clbad) t.err = h1p_pkg::ERR_HEADER;
            else if (body_left != 0) ph = h1p_pkg::PH_BODY;
            else t.done = 1;
          end else t.done = 1;
        end else if (lbytes > cfg_max_line) t.err = h1p_pkg::ERR_TOOLONG;
        else begin
          if (hlines < 256) hlines++;
          if (hlines > cfg_max_lines) t.err = h1p_pkg::ERR_TOOLONG;
          else if (!colon_seen) t.err = h1p_pkg::ERR_HEADER;
          else if (cfg_strict && !first_ok) t.err = h1p_pkg::ERR_HEADER;
          else if (hit_sel == h1p_pkg::SEL_TE) chunked = te_started && !te_fail && vmt == 7;
          else if (hit_sel == h1p_pkg::SEL_CL) begin
            lknown = 1; body_left = cl_val; clbad = !cl_digits || cl_over;
          end
        end
      end
      h1p_pkg::PH_CSIZE: begin
        if (!cs_digits || cs_over) t.err = h1p_pkg::ERR_HEADER;
        else begin
          chunk_left = cs_val; ph = cs_val != 0 ? h1p_pkg::PH_CDATA : h1p_pkg::PH_CEND;
        end
      end
      default: begin
        if (lbytes != 0) t.err = h1p_pkg::ERR_CHUNK;
        else t.done = 1;
      end
    endcase
    clear_line();
  endtask

  task automatic predict_tag(logic [7:0] c);
    t = '0;
    t.data = c;
    if (ph == h1p_pkg::PH_BODY) begin
      t.kind = h1p_pkg::KIND_BODY; body_left = body_left - 1;
      if (body_left == 0) begin
        t.fend = 1; t.done = 1;
      end
    end else if (ph == h1p_pkg::PH_CDATA) begin
      t.kind = h1p_pkg::KIND_BODY; chunk_left = chunk_left - 1;
      if (chunk_left == 0) begin
        t.fend = 1; ph = h1p_pkg::PH_CCR;
      end
    end else if (ph == h1p_pkg::PH_CCR) begin
      if (c == h1p_pkg::CH_CR) ph = h1p_pkg::PH_CLF; else t.err = h1p_pkg::ERR_CHUNK;
    end else if (ph == h1p_pkg::PH_CLF) begin
      if (c == h1p_pkg::CH_LF) begin
        ph = h1p_pkg::PH_CSIZE; t.fend = 1;
      end else t.err = h1p_pkg::ERR_CHUNK;
    end else if (pcr && c == h1p_pkg::CH_LF) begin
      pcr = 0;
      finish_line();
      t.kind = h1p_pkg::KIND_FRAME; t.idx = 0; t.fend = 1;
    end else begin
      if (pcr) begin
        pcr = 0; line_byte(h1p_pkg::CH_CR);
      end
      if (c == h1p_pkg::CH_CR) begin
        pcr = 1; t.kind = h1p_pkg::KIND_FRAME; t.idx = 0; t.fend = 0;
      end else line_byte(c);
    end
    if (ph == h1p_pkg::PH_START) begin
      t.rep = lbytes >= 5 && !pfx_fail; t.minor = 0; t.status = 0;
    end else begin
      t.rep = r_is; t.minor = r_minor; t.status = r_status;
    end
    tag_q.push_back(t);
    if (t.done || t.err != h1p_pkg::ERR_NONE) clear_message();
  endtask

  // drivers; tvalid stays up between items and is dropped while idling or draining
  task automatic send_byte(logic [7:0] c);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    predict_tag(c);
    bytes_sent++;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tag_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      h1p_pkg::REG_MAX_LINE: cfg_max_line = val;
      h1p_pkg::REG_MAX_LINES: cfg_max_lines = val[7:0];
      default: cfg_strict = val[0];
    endcase
  endtask

  always @(posedge clk) begin
    if (rst || hold_recv) m_tready <= 1'b0;
    else m_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    tag_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = m_tuser[2:0]; got.idx = m_tuser[4:3];
      got.data = m_tdata[7:0]; got.fend = m_tdata[8]; got.rep = m_tdata[9];
      got.minor = m_tdata[10]; got.status = m_tdata[26:11]; got.err = m_tdata[29:27];
      got.done = m_tlast;
      if (tag_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item %h", got);
      end else begin
        want = tag_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: kind %0d/%0d idx %0d/%0d data %h/%h end %b/%b ",
                      "done %b/%b rep %b/%b minor %b/%b status %0d/%0d err %0d/%0d"},
                     want.kind, got.kind, want.idx, got.idx, want.data, got.data,
                     want.fend, got.fend, want.done, got.done, want.rep, got.rep,
                     want.minor, got.minor, want.status, got.status, want.err, got.err);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("http1_message_stream_parser_unit regression: fail");
      $finish;
    end
  end

  // random message builders
  function automatic string rand_token(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(97, 122)))};
    return s;
  endfunction

  function automatic string rand_head();
    string s;
    if ($urandom_range(1)) s = $sformatf("HTTP/1.%0d %0d OK\r\n", $urandom_range(1),
                                         $urandom_range(100, 599));
    else s = $sformatf("%s /%s HTTP/1.%0d\r\n", $urandom_range(1) ? "GET" : "POST",
                       rand_token($urandom_range(0, 4)), $urandom_range(1));
    if ($urandom_range(1)) s = {s, "Host: ", rand_token($urandom_range(1, 5)), "\r\n"};
    return s;
  endfunction

  task automatic send_random_message();
    int n, kind;
    string s;
    kind = $urandom_range(9);
    s = rand_head();
    if (kind < 3) begin
      n = $urandom_range(0, 12);
      s = {s, $sformatf("%s: %0d\r\n\r\n", $urandom_range(1) ? "Content-Length" :
                        "CONTENT-length", n)};
      send_text(s);
      for (int i = 0; i < n; i++) send_byte($urandom_range(255));
    end else if (kind < 6) begin
      s = {s, $urandom_range(1) ? "Transfer-Encoding: chunked\r\n\r\n" :
              "transfer-ENCODING:  Chunked \r\n\r\n"};
      send_text(s);
      repeat ($urandom_range(0, 2)) begin
        n = $urandom_range(1, 10);
        send_text($sformatf("%h;x\r\n", 8'(n)));
        for (int i = 0; i < n; i++) send_byte($urandom_range(255));
        if ($urandom_range(9) == 0) send_byte($urandom_range(255));
        send_text("\r\n");
      end
      send_text("0\r\n");
      send_text($urandom_range(5) == 0 ? "x\r\n" : "\r\n");
    end else if (kind < 8) begin
      send_text({s, "\r\n"});
    end else begin
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++) send_byte($urandom_range(255));
      send_text("\r\n\r\n");
    end
  endtask

  // tests
  task automatic test_directed();
    send_text("GET / HTTP/1.1\r\nContent-Length: 3\r\n\r\nabc");
    send_text("HTTP/1.0 200 OK\r\nTransfer-Encoding: chunked\r\n\r\n2\r\nhi\r\n0\r\n\r\n");
    send_text("HTTP/1.1 99999 X\r\n");
    send_text("GET /\r\n");
    send_text("GET / HTTP/2.0\r\n");
    send_text("HTTP/1.1 2x\r\n: v\r\n");
    send_text("GET a\rb HTTP/1.1\r\nX y\r\n");
    send_text("GET / HTTP/1.1\r\nContent-Length: 99999999999999\r\n\r\n");
    send_text("GET / HTTP/1.1\r\nTransfer-Encoding: chunked\r\n\r\nzz\r\n");
    send_text("GET / HTTP/1.1\r\nTransfer-Encoding: chunked\r\n\r\nFFFFFFFFFFFF\r\n");
    send_text("GET / HTTP/1.1\r\nTransfer-Encoding: chunked\r\n\r\n1\r\naXY");
    send_text("GET / HTTP/1.1\r\nTransfer-Encoding: chunked\r\n\r\n0\r\nT: x\r\n");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("\r\n");
  endtask

  task automatic test_registers();
    write_reg(h1p_pkg::REG_MAX_LINE, 16'd0);
    send_text("GET / HTTP/1.1\r\nA: b\r\n");
    write_reg(h1p_pkg::REG_MAX_LINE, 16'hFFFF);
    write_reg(h1p_pkg::REG_MAX_LINES, 16'd0);
    send_text("GET / HTTP/1.1\r\nA: b\r\n");
    write_reg(h1p_pkg::REG_MAX_LINES, 16'd1);
    send_text("GET / HTTP/1.1\r\nA: b\r\nB: c\r\n");
    write_reg(h1p_pkg::REG_MAX_LINES, 16'hFF);
    write_reg(h1p_pkg::REG_STRICT, 16'd0);
    send_text("GET / HTTP/1.1\r\n:x\r\n@a: b\r\n\r\n");
    write_reg(h1p_pkg::REG_STRICT, 16'd1);
    send_text("GET / HTTP/1.1\r\n@a: b\r\n");
    write_reg(h1p_pkg::REG_MAX_LINE, 16'd12);
    write_reg(h1p_pkg::REG_MAX_LINES, 16'd3);
  endtask

  task automatic test_random(int sidle, int ridle, int count);
    int first;
    drain();
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    first = bytes_sent;
    while (bytes_sent - first < count) send_random_message();
  endtask

  task automatic test_backpressure();
    drain();
    send_idle_pct = 0;
    fork
      begin
        hold_recv = 1'b1;
        repeat (200) @(posedge clk);
        hold_recv = 1'b0;
      end
      send_text("GET / HTTP/1.1\r\nContent-Length: 4\r\n\r\nwxyz");
    join
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    clear_message();
    recv_idle_pct = 10;
    test_directed();
    test_registers();
    test_random(11, 84, 40);
    write_reg(h1p_pkg::REG_MAX_LINE, 16'd8192);
    write_reg(h1p_pkg::REG_MAX_LINES, 16'd100);
    test_random(84, 11, 40);
    test_random(0, 0, 40);
    test_backpressure();
    drain();
    if (mismatches == 0 && tag_q.size() == 0)
      $display("http1_message_stream_parser_unit regression: pass");
    else
      $display("http1_message_stream_parser_unit regression: fail");
    $finish;
  end

  initial begin
    clear_message();
  end

endmodule
